>>> rtl/lste_pkg.sv
// package for the link state table engine: payload types, codes and constants
package lste_pkg;

    localparam int ID_W          = 6;
    localparam int AGE_W         = 8;
    localparam int LS_W          = 2;
    localparam int NBR_CNT_W     = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;
    localparam int MAX_NODES_DEF = 64;

    localparam logic [LS_W-1:0]  LS_DISC     = 2'd0;
    localparam logic [LS_W-1:0]  LS_CONN     = 2'd1;
    localparam logic [LS_W-1:0]  LS_UNKNOWN  = 2'd2;
    localparam logic [AGE_W-1:0] AGE_INVALID = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ADDR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT = 2'd2;

    localparam logic [5:0]       SELF_ADDR_RST   = 6'd0;
    localparam logic [6:0]       NODE_COUNT_RST  = 7'd64;
    localparam logic [AGE_W-1:0] STALE_LIMIT_RST = 8'd16;

    typedef enum logic [1:0] {
        OP_HELLO,
        OP_MERGE,
        OP_AGE_TICK,
        OP_READ
    } t_op;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HELLO_W2,
        S_HELLO_CNT,
        S_SWEEP_RD,
        S_SWEEP_CHK,
        S_SWEEP_WR2,
        S_MERGE_CMP,
        S_MERGE_WR2,
        S_AGE,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [LS_W-1:0]  state;
        logic [AGE_W-1:0] age;
    } t_entry;

    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  sender_id;
        logic [ID_W-1:0]  node_id;
        logic [ID_W-1:0]  peer_id;
        logic [LS_W-1:0]  link_state;
        logic [AGE_W-1:0] link_age;
    } t_in_item;

    typedef struct packed {
        logic                 changed;
        logic [LS_W-1:0]      read_state;
        logic [AGE_W-1:0]     read_age;
        logic                 read_neighbor;
        logic [NBR_CNT_W-1:0] neighbor_count;
    } t_out_item;

endpackage

>>> rtl/link_state_table_engine_top.sv
// Link state table engine: one request at a time through a small sequencer around the
// table memory, which has one write port and one registered read port. After reset a
// clearing pass writes every entry, and no request is taken until it ends; configuration
// writes are taken at any time. A read looks up the table and then offers its result; a
// merge writes both directions of a link when its age is no larger than the stored one;
// a hello bumps the sender's hello counter, and when that count reaches the stale limit
// a liveness sweep visits every node. An age tick walks the whole table, one entry per
// cycle. A finished result waits in an output register, and the next request is taken
// meanwhile.
module link_state_table_engine_top #(
    parameter int MAX_NODES = lste_pkg::MAX_NODES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  lste_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output lste_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [lste_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lste_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lste_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IXW   = AW + 1;
    localparam logic [NW-1:0]  LAST_NODE  = NW'(MAX_NODES - 1);
    localparam logic [AW-1:0]  LAST_ENTRY = AW'(DEPTH - 1);
    localparam logic [IXW-1:0] DEPTH_IX   = IXW'(DEPTH);

    function automatic logic [NW-1:0] f_node(input logic [ID_W-1:0] id);
        return NW'(id);
    endfunction

    function automatic logic f_ok(input logic [ID_W-1:0] id);
        return int'(id) < MAX_NODES;
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [NW-1:0] row, input logic [NW-1:0] col);
        return AW'(row) * AW'(MAX_NODES) + AW'(col);
    endfunction

    t_state               r_state, n_state;
    logic [IXW-1:0]       r_idx, n_idx;
    logic [5:0]           r_self;
    logic [6:0]           r_node_count;
    logic [AGE_W-1:0]     r_stale;
    logic [ID_W-1:0]      r_snd, n_snd, r_nd, n_nd, r_pr, n_pr;
    logic [LS_W-1:0]      r_lst, n_lst;
    logic [AGE_W-1:0]     r_lage, n_lage;
    logic                 r_chg, n_chg;
    logic [LS_W-1:0]      r_rd_state, n_rd_state;
    logic [AGE_W-1:0]     r_rd_age, n_rd_age;
    logic                 r_rd_nb, n_rd_nb;
    logic [MAX_NODES-1:0] r_nb, n_nb;
    logic [NBR_CNT_W-1:0] r_nbr_cnt, n_nbr_cnt;
    logic [MAX_NODES-1:0] r_cnt_vld, n_cnt_vld;
    logic [AGE_W-1:0]     r_cnt_mem [MAX_NODES];
    logic [AGE_W-1:0]     r_cnt_q;
    logic                 r_cnt_vq;
    t_entry               r_mem [DEPTH];
    t_entry               r_mem_q;
    logic                 r_out_vld, n_out_vld;
    t_out_item            r_out;
    logic                 out_load;

    logic                 mem_we;
    logic [AW-1:0]        mem_wa, mem_ra;
    t_entry               mem_wd;
    logic                 cnt_we;
    logic [NW-1:0]        cnt_ra;
    logic [AGE_W-1:0]     cnt_new;
    logic                 self_ok;
    logic [NW-1:0]        self_n, sweep_n;
    logic                 merge_ok;
    logic [LS_W-1:0]      merge_st;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign self_ok  = f_ok(r_self);
    assign self_n   = f_node(r_self);
    assign sweep_n  = r_idx[NW-1:0];
    assign cnt_new  = (r_cnt_vq ? r_cnt_q : '0) + 1'b1;
    assign merge_st = (r_lst > LS_UNKNOWN) ? LS_UNKNOWN : r_lst;
    assign merge_ok = (i_in_data.node_id != r_self)
                   && ({1'b0, i_in_data.node_id} < r_node_count)
                   && ({1'b0, i_in_data.peer_id} < r_node_count)
                   && f_ok(i_in_data.node_id) && f_ok(i_in_data.peer_id);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_snd      = r_snd;
        n_nd       = r_nd;
        n_pr       = r_pr;
        n_lst      = r_lst;
        n_lage     = r_lage;
        n_chg      = r_chg;
        n_rd_state = r_rd_state;
        n_rd_age   = r_rd_age;
        n_rd_nb    = r_rd_nb;
        n_nb       = r_nb;
        n_nbr_cnt  = r_nbr_cnt;
        n_cnt_vld  = r_cnt_vld;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = '0;
        mem_ra     = f_addr(f_node(r_nd), f_node(r_pr));
        cnt_we     = 1'b0;
        cnt_ra     = f_node(r_snd);

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_idx[AW-1:0];
                mem_wd = '{state: LS_UNKNOWN, age: AGE_INVALID};
                if (r_idx[AW-1:0] == LAST_ENTRY) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                cnt_ra = f_node(i_in_data.sender_id);
                mem_ra = f_addr(f_node(i_in_data.node_id), f_node(i_in_data.peer_id));
                if (i_in_valid) begin
                    n_snd      = i_in_data.sender_id;
                    n_nd       = i_in_data.node_id;
                    n_pr       = i_in_data.peer_id;
                    n_lst      = i_in_data.link_state;
                    n_lage     = i_in_data.link_age;
                    n_chg      = 1'b0;
                    n_rd_state = '0;
                    n_rd_age   = '0;
                    n_rd_nb    = 1'b0;
                    case (i_in_data.op)
                        OP_HELLO: begin
                            if (!f_ok(i_in_data.sender_id)) begin
                                n_state = S_DONE;
                            end else if (!r_nb[f_node(i_in_data.sender_id)]) begin
                                n_nb[f_node(i_in_data.sender_id)] = 1'b1;
                                n_nbr_cnt = r_nbr_cnt + 1'b1;
                                n_chg     = 1'b1;
                                mem_we    = self_ok;
                                mem_wa    = f_addr(self_n, f_node(i_in_data.sender_id));
                                mem_wd    = '{state: LS_CONN, age: '0};
                                n_state   = S_HELLO_W2;
                            end else begin
                                n_state = S_HELLO_CNT;
                            end
                        end
                        OP_MERGE: begin
                            if (f_ok(i_in_data.sender_id)
                                && !r_nb[f_node(i_in_data.sender_id)]) begin
                                n_nb[f_node(i_in_data.sender_id)] = 1'b1;
                                n_nbr_cnt = r_nbr_cnt + 1'b1;
                            end
                            n_state = merge_ok ? S_MERGE_CMP : S_DONE;
                        end
                        OP_AGE_TICK: begin
                            n_idx   = '0;
                            n_state = S_AGE;
                        end
                        OP_READ: begin
                            if (f_ok(i_in_data.node_id) && f_ok(i_in_data.peer_id)) begin
                                n_state = S_READ;
                            end else begin
                                n_rd_state = LS_UNKNOWN;
                                n_rd_age   = AGE_INVALID;
                                n_state    = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_HELLO_W2: begin
                mem_we  = self_ok;
                mem_wa  = f_addr(f_node(r_snd), self_n);
                mem_wd  = '{state: LS_CONN, age: '0};
                n_state = S_HELLO_CNT;
            end
            S_HELLO_CNT: begin
                cnt_we = 1'b1;
                n_cnt_vld[f_node(r_snd)] = 1'b1;
                if (cnt_new == r_stale) begin
                    n_idx   = '0;
                    n_state = S_SWEEP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SWEEP_RD: begin
                cnt_ra  = sweep_n;
                n_state = S_SWEEP_CHK;
            end
            S_SWEEP_CHK, S_SWEEP_WR2: begin
                if (r_state == S_SWEEP_CHK && (!r_cnt_vq || r_cnt_q == '0)) begin
                    if (r_nb[sweep_n]) begin
                        n_nb[sweep_n] = 1'b0;
                        n_nbr_cnt = r_nbr_cnt - 1'b1;
                        n_chg     = 1'b1;
                    end
                    mem_we  = self_ok;
                    mem_wa  = f_addr(self_n, sweep_n);
                    mem_wd  = '{state: LS_DISC, age: '0};
                    n_state = S_SWEEP_WR2;
                end else begin
                    if (r_state == S_SWEEP_WR2) begin
                        mem_we = self_ok;
                        mem_wa = f_addr(sweep_n, self_n);
                        mem_wd = '{state: LS_DISC, age: '0};
                    end
                    if (sweep_n == LAST_NODE) begin
                        n_cnt_vld = '0;
                        n_state   = S_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SWEEP_RD;
                    end
                end
            end
            S_MERGE_CMP: begin
                if (r_lage <= r_mem_q.age) begin
                    mem_we  = 1'b1;
                    mem_wa  = f_addr(f_node(r_nd), f_node(r_pr));
                    mem_wd  = '{state: merge_st, age: r_lage};
                    n_chg   = 1'b1;
                    n_state = S_MERGE_WR2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MERGE_WR2: begin
                mem_we  = 1'b1;
                mem_wa  = f_addr(f_node(r_pr), f_node(r_nd));
                mem_wd  = '{state: merge_st, age: r_lage};
                n_state = S_DONE;
            end
            S_AGE: begin
                mem_ra = r_idx[AW-1:0];
                if (r_idx != '0 && r_mem_q.age != AGE_INVALID) begin
                    mem_we = 1'b1;
                    mem_wa = AW'(r_idx - 1'b1);
                    mem_wd = '{state: r_mem_q.state, age: r_mem_q.age + 1'b1};
                end
                if (r_idx == DEPTH_IX) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_READ: begin
                n_rd_state = r_mem_q.state;
                n_rd_age   = r_mem_q.age;
                n_rd_nb    = r_nb[f_node(r_pr)];
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_nb         <= '0;
            r_nbr_cnt    <= '0;
            r_cnt_vld    <= '0;
            r_out_vld    <= 1'b0;
            r_self       <= SELF_ADDR_RST;
            r_node_count <= NODE_COUNT_RST;
            r_stale      <= STALE_LIMIT_RST;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_nb      <= n_nb;
            r_nbr_cnt <= n_nbr_cnt;
            r_cnt_vld <= n_cnt_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SELF_ADDR:   r_self       <= i_cfg_data[5:0];
                    CFG_NODE_COUNT:  r_node_count <= i_cfg_data[6:0];
                    CFG_STALE_LIMIT: r_stale      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_snd      <= n_snd;
        r_nd       <= n_nd;
        r_pr       <= n_pr;
        r_lst      <= n_lst;
        r_lage     <= n_lage;
        r_chg      <= n_chg;
        r_rd_state <= n_rd_state;
        r_rd_age   <= n_rd_age;
        r_rd_nb    <= n_rd_nb;
        if (out_load) begin
            r_out <= '{changed:        r_chg,
                       read_state:     r_rd_state,
                       read_age:       r_rd_age,
                       read_neighbor:  r_rd_nb,
                       neighbor_count: r_nbr_cnt};
        end
    end

    // link table memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= r_mem[mem_ra];
    end

    // hello counter memory
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[f_node(r_snd)] <= cnt_new;
        end
        r_cnt_q  <= r_cnt_mem[cnt_ra];
        r_cnt_vq <= r_cnt_vld[cnt_ra];
    end

    a_nbr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nbr_cnt == NBR_CNT_W'($countones(r_nb)))
        else $error("neighbor count out of step with neighbor bits");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but sequencer stayed idle");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_vld) |=> r_out_vld)
        else $error("finished request not moved to output register");

    a_cnt_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_we |-> (r_state == S_HELLO_CNT))
        else $error("hello counter written outside hello update");

endmodule
